[design/kruskal_maze_union_find_macros.svh]
// assertion macros shared by the kruskal maze union-find design
`ifndef KRUSKAL_MAZE_UNION_FIND_MACROS_SVH
`define KRUSKAL_MAZE_UNION_FIND_MACROS_SVH

// same-cycle implication, checked outside reset
`define KMUF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define KMUF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/kmuf_pkg.sv]
// types and constants of the kruskal maze union-find engine
package kmuf_pkg;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int POS_W     = 4;

    // sequencer states
    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_A_WALK,
        ST_A_COMP,
        ST_B_WALK,
        ST_B_COMP,
        ST_LINK,
        ST_MERGE,
        ST_RESULT
    } kmuf_state_t;

    // strobes from the sequencer to the store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic right_we;
        logic down_we;
        logic wall_val;
    } kmuf_mem_ctl_t;

endpackage

[design/kruskal_maze_union_find.sv]
// Kruskal maze engine: a union-find store over a GRID_SIDE by GRID_SIDE grid in one
// single-port-read, single-port-write memory. A wall offer walks from the first cell
// to its root, then walks again pointing every visited cell at that root, and does the
// same for the second cell; each step is one memory read. When the two roots differ,
// linking writes the smaller root under the larger (the second under the first on a
// tie), and then writes the merged size on the larger. The time to a result grows with
// the tree depths of the two cells, which union by size holds to at most log2 of the
// cell count; when both cells already share a root, no link or merge is written.
// The next transaction can be accepted in the same cycle that the result is offered,
// but not before, so a new offer waits until the last result has gone to the output
// register. An offer outside the grid replies without touching the store. After reset,
// and on every clear transaction, a clearing pass writes the whole store, one cell a
// cycle, during which no transaction is accepted; a clear transaction replies when the
// pass ends. One result transaction follows each input transaction.
`include "kruskal_maze_union_find_macros.svh"

module kruskal_maze_union_find import kmuf_pkg::*; #(
    parameter int GRID_SIDE = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // along[3:0], across[7:4], dir[8]
    input  logic                 s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // removed[0], wall_col[4:1], wall_row[8:5],
                                            // wall_is_down[9], complete[10]
);

    localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
    localparam int IDX_W      = $clog2(CELL_COUNT);
    localparam int SZ_W       = $clog2(CELL_COUNT + 1);
    localparam int CALC_W     = IDX_W + POS_W;

    kmuf_state_t state_reg, state_next;

    logic [IDX_W-1:0] sweep_reg, sweep_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [IDX_W-1:0] walk_reg, walk_next;
    logic [IDX_W-1:0] c1_reg, c1_next;
    logic [IDX_W-1:0] c2_reg, c2_next;
    logic [IDX_W-1:0] ra_reg, ra_next;
    logic [IDX_W-1:0] rb_reg, rb_next;
    logic [IDX_W-1:0] big_reg, big_next;
    logic [SZ_W-1:0]  sa_reg, sa_next;
    logic [SZ_W-1:0]  sb_reg, sb_next;
    logic [SZ_W-1:0]  sum_reg, sum_next;
    logic             removed_reg, removed_next;
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic             down_reg, down_next;
    logic             clear_item_reg, clear_item_next;
    logic             complete_reg, complete_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic             m_removed_reg, m_removed_next;
    logic [POS_W-1:0] m_col_reg, m_col_next;
    logic [POS_W-1:0] m_row_reg, m_row_next;
    logic             m_down_reg, m_down_next;
    logic             m_complete_reg, m_complete_next;

    // store port signals
    kmuf_mem_ctl_t    ctl;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] rd_parent;
    logic [SZ_W-1:0]  rd_size;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_parent;
    logic [SZ_W-1:0]  wr_size;
    logic [IDX_W-1:0] wall_addr;

    // input decode
    logic              in_mode;
    logic [POS_W-1:0]  in_along;
    logic [POS_W-1:0]  in_across;
    logic              in_dir;
    logic [POS_W-1:0]  in_col;
    logic [POS_W-1:0]  in_row;
    logic              in_range;
    logic [CALC_W-1:0] c1_wide;
    logic [CALC_W-1:0] c2_wide;

    assign in_mode   = s_tuser;
    assign in_along  = s_tdata[3:0];
    assign in_across = s_tdata[7:4];
    assign in_dir    = s_tdata[8];
    assign in_col    = in_dir ? in_across : in_along;
    assign in_row    = in_dir ? in_along : in_across;
    assign in_range  = (CALC_W'(in_along) <= CALC_W'(GRID_SIDE - 2))
                    && (CALC_W'(in_across) <= CALC_W'(GRID_SIDE - 1));
    assign c1_wide   = CALC_W'(in_row) * CALC_W'(GRID_SIDE) + CALC_W'(in_col);
    assign c2_wide   = c1_wide + (in_dir ? CALC_W'(GRID_SIDE) : CALC_W'(1));

    kmuf_store #(
        .CELLS (CELL_COUNT)
    ) u_store (
        .aclk      (aclk),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .rd_parent (rd_parent),
        .rd_size   (rd_size),
        .wr_addr   (wr_addr),
        .wr_parent (wr_parent),
        .wr_size   (wr_size),
        .wall_addr (wall_addr)
    );

    // next state, store accesses and result loading
    always_comb begin
        state_next      = state_reg;
        sweep_next      = sweep_reg;
        cur_next        = cur_reg;
        walk_next       = walk_reg;
        c1_next         = c1_reg;
        c2_next         = c2_reg;
        ra_next         = ra_reg;
        rb_next         = rb_reg;
        big_next        = big_reg;
        sa_next         = sa_reg;
        sb_next         = sb_reg;
        sum_next        = sum_reg;
        removed_next    = removed_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        down_next       = down_reg;
        clear_item_next = clear_item_reg;
        complete_next   = complete_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_removed_next  = m_removed_reg;
        m_col_next      = m_col_reg;
        m_row_next      = m_row_reg;
        m_down_next     = m_down_reg;
        m_complete_next = m_complete_reg;
        ctl             = '0;
        rd_addr         = cur_reg;
        wr_addr         = walk_reg;
        wr_parent       = ra_reg;
        wr_size         = rd_size;
        wall_addr       = c1_reg;

        case (state_reg)
            // clearing pass: every cell its own root, size one, all walls up
            ST_SWEEP: begin
                ctl.wr_en    = 1'b1;
                ctl.right_we = 1'b1;
                ctl.down_we  = 1'b1;
                ctl.wall_val = 1'b1;
                wr_addr      = sweep_reg;
                wr_parent    = sweep_reg;
                wr_size      = SZ_W'(1);
                wall_addr    = sweep_reg;
                if (sweep_reg == IDX_W'(CELL_COUNT - 1)) begin
                    sweep_next = '0;
                    state_next = clear_item_reg ? ST_RESULT : ST_IDLE;
                end else begin
                    sweep_next = sweep_reg + IDX_W'(1);
                end
            end

            // take a transaction and start a clear, an out-of-grid reply or the first root walk
            ST_IDLE: begin
                if (s_tvalid) begin
                    removed_next = 1'b0;
                    if (in_mode) begin
                        clear_item_next = 1'b1;
                        complete_next   = 1'b0;
                        col_next        = '0;
                        row_next        = '0;
                        down_next       = 1'b0;
                        state_next      = ST_SWEEP;
                    end else begin
                        clear_item_next = 1'b0;
                        col_next        = in_col;
                        row_next        = in_row;
                        down_next       = in_dir;
                        if (in_range) begin
                            c1_next    = c1_wide[IDX_W-1:0];
                            c2_next    = c2_wide[IDX_W-1:0];
                            cur_next   = c1_wide[IDX_W-1:0];
                            rd_addr    = c1_wide[IDX_W-1:0];
                            ctl.rd_en  = 1'b1;
                            state_next = ST_A_WALK;
                        end else begin
                            state_next = ST_RESULT;
                        end
                    end
                end
            end

            // walk up from the first cell
            ST_A_WALK: begin
                ctl.rd_en = 1'b1;
                if (rd_parent == cur_reg) begin
                    ra_next    = cur_reg;
                    sa_next    = rd_size;
                    walk_next  = c1_reg;
                    rd_addr    = c1_reg;
                    state_next = ST_A_COMP;
                end else begin
                    cur_next = rd_parent;
                    rd_addr  = rd_parent;
                end
            end

            // point the first path at its root
            ST_A_COMP: begin
                ctl.rd_en = 1'b1;
                if (walk_reg == ra_reg) begin
                    cur_next   = c2_reg;
                    rd_addr    = c2_reg;
                    state_next = ST_B_WALK;
                end else begin
                    ctl.wr_en = 1'b1;
                    wr_addr   = walk_reg;
                    wr_parent = ra_reg;
                    wr_size   = rd_size;
                    walk_next = rd_parent;
                    rd_addr   = rd_parent;
                end
            end

            // walk up from the second cell
            ST_B_WALK: begin
                ctl.rd_en = 1'b1;
                if (rd_parent == cur_reg) begin
                    rb_next    = cur_reg;
                    sb_next    = rd_size;
                    walk_next  = c2_reg;
                    rd_addr    = c2_reg;
                    state_next = ST_B_COMP;
                end else begin
                    cur_next = rd_parent;
                    rd_addr  = rd_parent;
                end
            end

            // point the second path at its root
            ST_B_COMP: begin
                if (walk_reg == rb_reg) begin
                    state_next = ST_LINK;
                end else begin
                    ctl.rd_en = 1'b1;
                    ctl.wr_en = 1'b1;
                    wr_addr   = walk_reg;
                    wr_parent = rb_reg;
                    wr_size   = rd_size;
                    walk_next = rd_parent;
                    rd_addr   = rd_parent;
                end
            end

            // when the roots differ, hang the smaller root under the larger and knock the wall down
            ST_LINK: begin
                if (ra_reg == rb_reg) begin
                    state_next = ST_RESULT;
                end else begin
                    ctl.wr_en    = 1'b1;
                    ctl.right_we = !down_reg;
                    ctl.down_we  = down_reg;
                    ctl.wall_val = 1'b0;
                    wall_addr    = c1_reg;
                    if (sa_reg < sb_reg) begin
                        wr_addr   = ra_reg;
                        wr_parent = rb_reg;
                        wr_size   = sa_reg;
                        big_next  = rb_reg;
                    end else begin
                        wr_addr   = rb_reg;
                        wr_parent = ra_reg;
                        wr_size   = sb_reg;
                        big_next  = ra_reg;
                    end
                    sum_next     = sa_reg + sb_reg;
                    removed_next = 1'b1;
                    state_next   = ST_MERGE;
                end
            end

            // new size on the surviving root
            ST_MERGE: begin
                ctl.wr_en     = 1'b1;
                wr_addr       = big_reg;
                wr_parent     = big_reg;
                wr_size       = sum_reg;
                complete_next = (sum_reg == SZ_W'(CELL_COUNT));
                state_next    = ST_RESULT;
            end

            // hand the result to the output register once it is free
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    m_removed_next  = removed_reg;
                    m_col_next      = col_reg;
                    m_row_next      = row_reg;
                    m_down_next     = down_reg;
                    m_complete_next = complete_reg;
                    clear_item_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            sweep_reg      <= '0;
            clear_item_reg <= 1'b0;
            complete_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            clear_item_reg <= clear_item_next;
            complete_reg   <= complete_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        walk_reg       <= walk_next;
        c1_reg         <= c1_next;
        c2_reg         <= c2_next;
        ra_reg         <= ra_next;
        rb_reg         <= rb_next;
        big_reg        <= big_next;
        sa_reg         <= sa_next;
        sb_reg         <= sb_next;
        sum_reg        <= sum_next;
        removed_reg    <= removed_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        down_reg       <= down_next;
        m_removed_reg  <= m_removed_next;
        m_col_reg      <= m_col_next;
        m_row_reg      <= m_row_next;
        m_down_reg     <= m_down_next;
        m_complete_reg <= m_complete_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 11){1'b0}}, m_complete_reg, m_down_reg,
                       m_row_reg, m_col_reg, m_removed_reg};

    // a compression write never hits the cell being read in the same cycle
    `KMUF_ASSERT_NOW(a_no_rw_clash, ctl.rd_en && ctl.wr_en, rd_addr != wr_addr,
        "store read and write to the same cell in one cycle")
    // the grid only becomes one set through a merge
    `KMUF_ASSERT_NOW(a_complete_from_merge, $rose(complete_reg),
        $past(state_reg) == ST_MERGE, "complete raised outside a merge")
    // a result transaction is only offered from the result state
    `KMUF_ASSERT_NOW(a_result_source, $rose(m_tvalid_reg),
        $past(state_reg) == ST_RESULT, "result offered outside the result state")

endmodule

[design/kmuf_store.sv]
// union-find store and wall marks, synchronous memories with registered read
module kmuf_store import kmuf_pkg::*; #(
    parameter int CELLS = 256
) (
    input  logic                             aclk,
    input  kmuf_mem_ctl_t                    ctl,
    input  logic [$clog2(CELLS)-1:0]         rd_addr,
    output logic [$clog2(CELLS)-1:0]         rd_parent,
    output logic [$clog2(CELLS+1)-1:0]       rd_size,
    input  logic [$clog2(CELLS)-1:0]         wr_addr,
    input  logic [$clog2(CELLS)-1:0]         wr_parent,
    input  logic [$clog2(CELLS+1)-1:0]       wr_size,
    input  logic [$clog2(CELLS)-1:0]         wall_addr
);

    localparam int IDX_W = $clog2(CELLS);
    localparam int SZ_W  = $clog2(CELLS + 1);

    // each entry holds {set size, parent}
    logic [SZ_W+IDX_W-1:0] uf_mem [CELLS];
    logic                  right_walls [CELLS];
    logic                  down_walls [CELLS];
    logic [SZ_W+IDX_W-1:0] rd_entry_reg;

    // registered read port
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_entry_reg <= uf_mem[rd_addr];
        end
    end

    // write port
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            uf_mem[wr_addr] <= {wr_size, wr_parent};
        end
    end

    // wall marks
    always_ff @(posedge aclk) begin
        if (ctl.right_we) begin
            right_walls[wall_addr] <= ctl.wall_val;
        end
        if (ctl.down_we) begin
            down_walls[wall_addr] <= ctl.wall_val;
        end
    end

    assign rd_parent = rd_entry_reg[IDX_W-1:0];
    assign rd_size   = rd_entry_reg[SZ_W+IDX_W-1:IDX_W];

endmodule
